/* rtl/pcsl_pkg.sv */
package pcsl_pkg;

    localparam int SLOT_COUNT = 24;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W  = 20;
    localparam int PAGE_W  = ADDR_W - PAGE_SHIFT;
    localparam int OFFS_W  = PAGE_SHIFT;
    localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TAG_W   = 8;
    localparam int AGE_W   = 16;
    localparam int CMP_W   = (PAGE_W > TAG_W) ? PAGE_W : TAG_W;

    localparam logic [TAG_W-1:0] EMPTY_TAG = 8'hff;

    localparam int SLOT_OUT_W  = 5;
    localparam int OFFS_OUT_W  = 12;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    // carrier walked down the cell chain, one cell per cycle
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
        logic              hit;
        logic [IDX_W-1:0]  slot;
        logic [AGE_W-1:0]  best;
        logic [IDX_W-1:0]  victim;
        logic [TAG_W-1:0]  victim_tag;
    } t_carry;

    // replacement command broadcast to every cell on a miss
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] victim;
        logic [TAG_W-1:0] tag;
    } t_upd;

endpackage

/* rtl/pcsl_cell.sv */
module pcsl_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pcsl_pkg::IDX_W-1:0] i_index,
    input  pcsl_pkg::t_carry           i_carry,
    input  pcsl_pkg::t_upd             i_upd,
    output pcsl_pkg::t_carry           o_carry
);

    logic [pcsl_pkg::TAG_W-1:0] r_tag;
    logic [pcsl_pkg::AGE_W-1:0] r_age;
    pcsl_pkg::t_carry           r_carry;
    pcsl_pkg::t_carry           n_carry;
    logic [pcsl_pkg::CMP_W-1:0] w_tag_x;
    logic [pcsl_pkg::CMP_W-1:0] w_page_x;
    logic                       w_mine;

    assign w_tag_x  = pcsl_pkg::CMP_W'(r_tag);
    assign w_page_x = pcsl_pkg::CMP_W'(i_carry.page);
    assign w_mine   = (i_upd.victim == i_index);

    always_comb begin
        n_carry = i_carry;
        if (i_carry.valid) begin
            if (!i_carry.hit && r_tag != pcsl_pkg::EMPTY_TAG && w_tag_x == w_page_x) begin
                n_carry.hit  = 1'b1;
                n_carry.slot = i_index;
            end
            // first cell seeds the victim search
            if (i_index == '0 || r_age > i_carry.best) begin
                n_carry.best       = r_age;
                n_carry.victim     = i_index;
                n_carry.victim_tag = r_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag         <= pcsl_pkg::EMPTY_TAG;
            r_age         <= '0;
            r_carry.valid <= 1'b0;
        end else begin
            r_carry <= n_carry;
            if (i_upd.en) begin
                if (w_mine) begin
                    r_age <= '0;
                    r_tag <= i_upd.tag;
                end else begin
                    r_age <= r_age + 1'b1;
                end
            end
        end
    end

    assign o_carry = r_carry;

endmodule

/* rtl/page_cache_slot_lookup_aged_fifo.sv */
// channel   | dir | signals                   | contents
// s_axis    | in  | tvalid tready tdata[23:0] | address
// m_axis    | out | tvalid tready tdata[39:0] | slot, offset, fill_page, evicted_page
//           |     | tuser[0]                  | hit
// One transaction at a time; a lookup walks the slot cells one per cycle, then its
// result passes through r_fin (S_FIN) into the output register, and the next address
// is taken only once the previous lookup has left S_FIN for S_IDLE.
// The result sits in an output register; the next address is taken while it waits.
// Synchronous active-low reset empties every slot and clears all ages.
// A stalled result holds the following one in S_FIN, and no address is taken meanwhile.
module page_cache_slot_lookup_aged_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [pcsl_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // [19:0] address
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [4:0] slot, [16:5] offset, [24:17] fill_page, [32:25] evicted_page
    output logic [pcsl_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    output logic                           o_m_axis_tuser   // [0] hit
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state                          r_state, n_state;
    pcsl_pkg::t_carry                r_launch, n_launch;
    pcsl_pkg::t_carry                r_fin, n_fin;
    logic [pcsl_pkg::OFFS_W-1:0]     r_offs, n_offs;
    logic                            r_m_tvalid, n_m_tvalid;
    logic [pcsl_pkg::M_TDATA_W-1:0]  r_m_tdata, n_m_tdata;
    logic                            r_m_tuser, n_m_tuser;

    pcsl_pkg::t_carry                w_chain [0:pcsl_pkg::SLOT_COUNT];
    pcsl_pkg::t_carry                w_tail;
    pcsl_pkg::t_upd                  w_upd;
    logic                            w_in_acc;
    logic                            w_out_free;
    logic [31:0]                     w_slot32;
    logic [31:0]                     w_page32;
    logic [31:0]                     w_offs32;
    logic [31:0]                     w_tail_page32;
    logic [pcsl_pkg::SLOT_OUT_W-1:0] w_slot;
    logic [pcsl_pkg::TAG_W-1:0]      w_fill;
    logic [pcsl_pkg::TAG_W-1:0]      w_evict;

    assign w_chain[0] = r_launch;
    assign w_tail     = w_chain[pcsl_pkg::SLOT_COUNT];

    for (genvar g = 0; g < pcsl_pkg::SLOT_COUNT; g++) begin : g_cell
        pcsl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (pcsl_pkg::IDX_W'(g)),
            .i_carry (w_chain[g]),
            .i_upd   (w_upd),
            .o_carry (w_chain[g+1])
        );
    end

    assign w_tail_page32 = 32'(w_tail.page);
    assign w_upd.en      = (r_state == S_RUN) && w_tail.valid && !w_tail.hit;
    assign w_upd.victim  = w_tail.victim;
    assign w_upd.tag     = w_tail_page32[pcsl_pkg::TAG_W-1:0];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_m_tvalid || i_m_axis_tready;

    assign w_slot32 = r_fin.hit ? 32'(r_fin.slot) : 32'(r_fin.victim);
    assign w_page32 = 32'(r_fin.page);
    assign w_offs32 = 32'(r_offs);
    assign w_slot   = w_slot32[pcsl_pkg::SLOT_OUT_W-1:0];
    assign w_fill   = r_fin.hit ? '0 : w_page32[pcsl_pkg::TAG_W-1:0];
    assign w_evict  = r_fin.hit ? '0 : r_fin.victim_tag;

    always_comb begin
        n_state    = r_state;
        n_launch   = r_launch;
        n_fin      = r_fin;
        n_offs     = r_offs;
        n_m_tvalid = r_m_tvalid;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;

        n_launch.valid = 1'b0;
        if (r_m_tvalid && i_m_axis_tready) begin
            n_m_tvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_launch.valid      = 1'b1;
                    n_launch.page       = i_s_axis_tdata[pcsl_pkg::ADDR_W-1:pcsl_pkg::PAGE_SHIFT];
                    n_launch.hit        = 1'b0;
                    n_launch.slot       = '0;
                    n_launch.best       = '0;
                    n_launch.victim     = '0;
                    n_launch.victim_tag = '0;
                    n_offs              = i_s_axis_tdata[pcsl_pkg::OFFS_W-1:0];
                    n_state             = S_RUN;
                end
            end
            S_RUN: begin
                if (w_tail.valid) begin
                    n_fin   = w_tail;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_tuser  = r_fin.hit;
                    n_m_tdata  = {7'd0, w_evict, w_fill,
                                  w_offs32[pcsl_pkg::OFFS_OUT_W-1:0], w_slot};
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_launch.valid <= 1'b0;
            r_m_tvalid     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_launch   <= n_launch;
            r_fin      <= n_fin;
            r_offs     <= n_offs;
            r_m_tvalid <= n_m_tvalid;
            r_m_tdata  <= n_m_tdata;
            r_m_tuser  <= n_m_tuser;
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

endmodule

/* sim/page_cache_slot_lookup_aged_fifo_test.sv */
`timescale 1ns / 100ps

module page_cache_slot_lookup_aged_fifo_test;

    typedef struct packed {
        logic       hit;
        logic [4:0] slot;
        logic [11:0] offset;
        logic [7:0] fill_page;
        logic [7:0] evicted_page;
    } t_lookup_result;

    localparam logic [19:0] TOP_ADDRESS = 20'hfefff;
    localparam int          DRAIN_CYCLES = 2 * (pcsl_pkg::SLOT_COUNT + 3);

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [pcsl_pkg::S_TDATA_W-1:0] i_s_axis_tdata = '0;   // [19:0] address
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    // [4:0] slot, [16:5] offset, [24:17] fill_page, [32:25] evicted_page
    logic [pcsl_pkg::M_TDATA_W-1:0] o_m_axis_tdata;
    logic                           o_m_axis_tuser;        // [0] hit

    logic [7:0]     slot_tag [pcsl_pkg::SLOT_COUNT];
    logic [15:0]    age_model [pcsl_pkg::SLOT_COUNT];
    t_lookup_result pending_lookups[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int hit_count = 0;
    int miss_count = 0;
    int empty_page_count = 0;

    page_cache_slot_lookup_aged_fifo u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // cache state after reset: every slot empty, every age zero
    function automatic void reset_cache_state();
        for (int i = 0; i < pcsl_pkg::SLOT_COUNT; i++) begin
            slot_tag[i]  = pcsl_pkg::EMPTY_TAG;
            age_model[i] = '0;
        end
    endfunction

    // hit on the lowest matching slot, otherwise evict the first oldest slot
    function automatic t_lookup_result predict_lookup(input logic [19:0] addr);
        t_lookup_result r;
        logic [7:0]     page;
        logic [15:0]    best;
        int             victim;
        bit             found;
        page   = 8'(addr >> pcsl_pkg::PAGE_SHIFT);
        r      = '0;
        r.offset = addr[11:0];
        found  = 1'b0;
        for (int i = 0; i < pcsl_pkg::SLOT_COUNT; i++) begin
            if (!found && slot_tag[i] != pcsl_pkg::EMPTY_TAG && slot_tag[i] == page) begin
                found  = 1'b1;
                r.hit  = 1'b1;
                r.slot = 5'(i);
            end
        end
        if (!found) begin
            best   = '0;
            victim = 0;
            for (int i = 0; i < pcsl_pkg::SLOT_COUNT; i++) begin
                if (age_model[i] > best) begin
                    best   = age_model[i];
                    victim = i;
                end
                age_model[i] = age_model[i] + 16'd1;
            end
            r.slot            = 5'(victim);
            r.fill_page       = page;
            r.evicted_page    = slot_tag[victim];
            slot_tag[victim]  = page;
            age_model[victim] = '0;
        end
        return r;
    endfunction

    task automatic send_address(input logic [19:0] addr);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(pcsl_pkg::S_TDATA_W - 20){1'b0}}, addr};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_lookups.push_back(predict_lookup(addr));
        sent_count++;
        if (addr[19:12] == pcsl_pkg::EMPTY_TAG)
            empty_page_count++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [19:0] pick_address(input int pool_base, input int pool_size);
        logic [7:0]  page;
        logic [11:0] offs;
        int          roll;
        roll = $urandom_range(99);
        if (roll < 5)
            page = pcsl_pkg::EMPTY_TAG;
        else if (roll < 17)
            page = 8'($urandom_range(254));
        else
            page = 8'((pool_base + $urandom_range(pool_size - 1)) % 255);
        case ($urandom_range(9))
            0:       offs = 12'h000;
            1:       offs = 12'hfff;
            default: offs = 12'($urandom());
        endcase
        return {page, offs};
    endfunction

    // result side: random back-pressure and comparison against the oldest prediction
    always @(posedge i_clk) begin
        t_lookup_result want;
        t_lookup_result got;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.hit          = o_m_axis_tuser;
                got.slot         = o_m_axis_tdata[4:0];
                got.offset       = o_m_axis_tdata[16:5];
                got.fill_page    = o_m_axis_tdata[24:17];
                got.evicted_page = o_m_axis_tdata[32:25];
                if (pending_lookups.size() == 0) begin
                    $display("%0t: unexpected result hit=%0d tdata=%h", $time,
                             o_m_axis_tuser, o_m_axis_tdata);
                    error_count++;
                end else begin
                    want = pending_lookups.pop_front();
                    checked_count++;
                    if (want.hit) hit_count++; else miss_count++;
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit expected %0d actual %0d", $time,
                                 want.hit, got.hit);
                        error_count++;
                    end
                    if (got.slot !== want.slot) begin
                        $display("%0t: slot expected %0d actual %0d", $time,
                                 want.slot, got.slot);
                        error_count++;
                    end
                    if (got.offset !== want.offset) begin
                        $display("%0t: offset expected %h actual %h", $time,
                                 want.offset, got.offset);
                        error_count++;
                    end
                    if (got.fill_page !== want.fill_page) begin
                        $display("%0t: fill_page expected %h actual %h", $time,
                                 want.fill_page, got.fill_page);
                        error_count++;
                    end
                    if (got.evicted_page !== want.evicted_page) begin
                        $display("%0t: evicted_page expected %h actual %h", $time,
                                 want.evicted_page, got.evicted_page);
                        error_count++;
                    end
                    if (o_m_axis_tdata[pcsl_pkg::M_TDATA_W-1:33] !== '0) begin
                        $display("%0t: tdata padding expected 0 actual %h", $time,
                                 o_m_axis_tdata[pcsl_pkg::M_TDATA_W-1:33]);
                        error_count++;
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // field extremes, first misses into empty slots, hits at both offset ends
    task automatic test_directed_extremes();
        send_idle_pct = 0;
        recv_idle_pct = 30;
        send_address(20'h00000);
        send_address(20'h00fff);
        send_address(TOP_ADDRESS);
        send_address(20'hfe000);
        send_address(20'haaaaa);
        send_address(20'h55555);
        send_address(20'h00800);
        send_address(20'haa001);
        send_address(20'h01000);
    endtask

    // page 255 is the empty mark: always a miss and leaves the victim slot empty
    task automatic test_empty_mark_page();
        send_address(20'hff000);
        send_address(20'hfffff);
        send_address(20'hff7a5);
        send_address(20'h00123);
        send_address(20'h02abc);
        send_address(20'hfe800);
    endtask

    // sender holds off until every outstanding lookup has returned
    task automatic test_drain_pause();
        int base;
        base = $urandom_range(254);
        for (int n = 0; n < 12; n++) send_address(pick_address(base, 30));
        wait_drained();
        for (int n = 0; n < 12; n++) send_address(pick_address(base, 30));
    endtask

    // bursts over a working set of pages near the slot count, so hits and
    // FIFO evictions both happen, mixed with stray pages
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int count);
        int left;
        int burst;
        int base;
        int pool;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        left = count;
        while (left > 0) begin
            base  = $urandom_range(254);
            pool  = $urandom_range(6, 40);
            burst = $urandom_range(20, 80);
            if (burst > left) burst = left;
            for (int n = 0; n < burst; n++) send_address(pick_address(base, pool));
            left -= burst;
        end
    endtask

    initial begin
        reset_cache_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_empty_mark_page();
        test_random_traffic(25, 57, 580);
        test_drain_pause();
        test_random_traffic(57, 25, 560);
        test_random_traffic(0, 0, 580);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_lookups.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_lookups.size());
            error_count++;
        end

        $display("Lookups sent %0d, results checked %0d (%0d hits, %0d misses).",
                 sent_count, checked_count, hit_count, miss_count);
        $display("Page 255 accesses %0d; three idle patterns plus one full drain.",
                 empty_page_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/pcsl_pkg.sv
rtl/pcsl_cell.sv
rtl/page_cache_slot_lookup_aged_fifo.sv
sim/page_cache_slot_lookup_aged_fifo_test.sv
